FILE: hdl/sdochk_pkg.sv
// ----------------------------------------------------------------------------
// SDO transfer response checker package
// Shared types, codes and a helper function for the response checker.
// ----------------------------------------------------------------------------
package sdochk_pkg;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 112;

  // Request kinds carried in tuser.
  localparam logic REQ_START    = 1'b0;
  localparam logic REQ_RESPONSE = 1'b1;

  // Command codes of start and response transactions.
  localparam logic [2:0] CMD_UPLOAD       = 3'd0;
  localparam logic [2:0] CMD_UPLOAD_SEG   = 3'd1;
  localparam logic [2:0] CMD_DOWNLOAD     = 3'd2;
  localparam logic [2:0] CMD_DOWNLOAD_SEG = 3'd3;
  localparam logic [2:0] CMD_ABORT        = 3'd4;
  localparam logic [2:0] KIND_OTHER       = 3'd4;

  localparam logic [1:0] FCLS_SDO = 2'd0;

  localparam logic [15:0] MBX_HDR_LEN   = 16'd10;
  localparam logic [2:0]  SEG_MAX_BYTES = 3'd7;
  localparam logic [2:0]  EXP_MAX_BYTES = 3'd4;
  localparam logic [2:0]  COUNTER_MAX   = 3'd7;
  localparam logic [2:0]  COUNTER_FIRST = 3'd1;

  localparam logic [3:0] OFFS_HEADER = 4'd0;
  localparam logic [3:0] OFFS_WORD1  = 4'd4;
  localparam logic [3:0] OFFS_WORD2  = 4'd8;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_CONTINUE = 2'd1,
    ACT_FINALIZE = 2'd2,
    ACT_START    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_RUNNING     = 3'd0,
    ST_SUCCESS     = 3'd1,
    ST_WRONG_SVC   = 3'd2,
    ST_BUF_SMALL   = 3'd3,
    ST_BAD_TOGGLE  = 3'd4,
    ST_UNKNOWN_SVC = 3'd5,
    ST_ABORTED     = 3'd6
  } status_e;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  command_code;
    logic [15:0] obj_index;
    logic [7:0]  obj_subindex;
    logic [1:0]  frame_class;
    logic        toggle_bit;
    logic        transfer_kind;
    logic [1:0]  block_field;
    logic        size_flag;
    logic [15:0] mailbox_len;
    logic [31:0] payload_word0;
    logic [31:0] payload_word1;
  } item_t;

  typedef struct packed {
    logic [2:0]  pending_kind;
    logic [15:0] pending_index;
    logic [7:0]  pending_subindex;
    logic        expected_toggle;
    logic [31:0] buffer_capacity;
    logic [31:0] received_total;
    logic [2:0]  session_count;
    logic        xfer_open;
  } state_t;

  typedef struct packed {
    action_e     action;
    status_e     status;
    logic [31:0] abort_code;
    logic [3:0]  copy_offset;
    logic [31:0] copy_bytes;
  } result_t;

  // Session counter runs 1..7 and wraps back to 1.
  function automatic logic [2:0] next_count(input logic [2:0] cnt);
    logic [2:0] res;
    if (cnt == COUNTER_MAX) begin
      res = COUNTER_FIRST;
    end else begin
      res = cnt + 3'd1;
    end
    return res;
  endfunction

endpackage

FILE: hdl/sdochk_classify.sv
// ----------------------------------------------------------------------------
// SDO response classifier
// Classifies one start or response transaction against the open transfer and
// computes the result fields and the next transfer state.
// ----------------------------------------------------------------------------
module sdochk_classify (
  input  sdochk_pkg::item_t   item_i,
  input  sdochk_pkg::state_t  state_i,
  output sdochk_pkg::result_t result_o,
  output sdochk_pkg::state_t  state_o
);

  logic        addr_checked;
  logic        addr_mismatch;
  logic        related;
  logic [2:0]  exp_size;
  logic [15:0] body_len;
  logic [2:0]  short_seg_size;
  logic [31:0] seg_size;
  logic [3:0]  seg_offset;
  logic        seg_overflow;

  // Only plain upload and download requests are matched by object address.
  assign addr_checked  = (state_i.pending_kind == sdochk_pkg::CMD_UPLOAD) ||
                         (state_i.pending_kind == sdochk_pkg::CMD_DOWNLOAD);
  assign addr_mismatch = (item_i.obj_index != state_i.pending_index) ||
                         (item_i.obj_subindex != state_i.pending_subindex);
  assign related       = state_i.xfer_open && (item_i.frame_class == sdochk_pkg::FCLS_SDO) &&
                         !(addr_checked && addr_mismatch);

  assign exp_size = sdochk_pkg::EXP_MAX_BYTES - {1'b0, item_i.block_field};
  assign body_len = (item_i.mailbox_len >= sdochk_pkg::MBX_HDR_LEN) ?
                    (item_i.mailbox_len - sdochk_pkg::MBX_HDR_LEN) : 16'd0;

  // A minimal segment carries up to seven bytes right after the header.
  assign short_seg_size = sdochk_pkg::SEG_MAX_BYTES - {item_i.size_flag, item_i.block_field};
  assign seg_size       = (item_i.mailbox_len == sdochk_pkg::MBX_HDR_LEN) ?
                          {29'd0, short_seg_size} : item_i.payload_word0;
  assign seg_offset     = (item_i.mailbox_len == sdochk_pkg::MBX_HDR_LEN) ?
                          sdochk_pkg::OFFS_HEADER : sdochk_pkg::OFFS_WORD1;
  assign seg_overflow   = ({1'b0, state_i.received_total} + {1'b0, seg_size}) >
                          {1'b0, state_i.buffer_capacity};

  always_comb begin
    state_o  = state_i;
    result_o = '{action:      sdochk_pkg::ACT_NONE,
                 status:      sdochk_pkg::ST_RUNNING,
                 abort_code:  32'd0,
                 copy_offset: sdochk_pkg::OFFS_HEADER,
                 copy_bytes:  32'd0};

    if (item_i.req_type == sdochk_pkg::REQ_START) begin
      state_o.pending_kind     = item_i.command_code;
      state_o.pending_index    = item_i.obj_index;
      state_o.pending_subindex = item_i.obj_subindex;
      state_o.buffer_capacity  = item_i.payload_word0;
      state_o.received_total   = 32'd0;
      state_o.expected_toggle  = 1'b0;
      state_o.xfer_open        = 1'b1;
      state_o.session_count    = sdochk_pkg::next_count(state_i.session_count);
      result_o.action          = sdochk_pkg::ACT_START;
    end else if (related) begin
      result_o.action = sdochk_pkg::ACT_FINALIZE;
      priority if (item_i.command_code == sdochk_pkg::CMD_ABORT) begin
        result_o.status     = sdochk_pkg::ST_ABORTED;
        result_o.abort_code = item_i.payload_word0;
      end else if (state_i.pending_kind == sdochk_pkg::CMD_UPLOAD) begin
        priority if (item_i.command_code != sdochk_pkg::CMD_UPLOAD) begin
          result_o.status = sdochk_pkg::ST_WRONG_SVC;
        end else if (item_i.transfer_kind) begin
          if (state_i.buffer_capacity < {29'd0, exp_size}) begin
            result_o.status = sdochk_pkg::ST_BUF_SMALL;
          end else begin
            result_o.copy_offset   = sdochk_pkg::OFFS_HEADER;
            result_o.copy_bytes    = {29'd0, exp_size};
            state_o.received_total = {29'd0, exp_size};
            result_o.status        = sdochk_pkg::ST_SUCCESS;
          end
        end else if (state_i.buffer_capacity < item_i.payload_word0) begin
          result_o.status = sdochk_pkg::ST_BUF_SMALL;
        end else if ({16'd0, body_len} >= item_i.payload_word0) begin
          result_o.copy_offset   = sdochk_pkg::OFFS_WORD1;
          result_o.copy_bytes    = item_i.payload_word0;
          state_o.received_total = item_i.payload_word0;
          result_o.status        = sdochk_pkg::ST_SUCCESS;
        end else if (item_i.payload_word1 > state_i.buffer_capacity) begin
          result_o.status = sdochk_pkg::ST_BUF_SMALL;
        end else begin
          // Segmented upload opens; the first chunk follows the size word.
          result_o.copy_offset    = sdochk_pkg::OFFS_WORD2;
          result_o.copy_bytes     = item_i.payload_word1;
          state_o.received_total  = item_i.payload_word1;
          state_o.pending_kind    = sdochk_pkg::CMD_UPLOAD_SEG;
          state_o.expected_toggle = 1'b0;
          result_o.action         = sdochk_pkg::ACT_CONTINUE;
        end
      end else if (state_i.pending_kind == sdochk_pkg::CMD_UPLOAD_SEG) begin
        priority if (item_i.command_code != sdochk_pkg::CMD_UPLOAD_SEG) begin
          result_o.status = sdochk_pkg::ST_WRONG_SVC;
        end else if (item_i.toggle_bit != state_i.expected_toggle) begin
          result_o.status = sdochk_pkg::ST_BAD_TOGGLE;
        end else if (seg_overflow) begin
          result_o.status = sdochk_pkg::ST_BUF_SMALL;
        end else begin
          result_o.copy_offset   = seg_offset;
          result_o.copy_bytes    = seg_size;
          state_o.received_total = state_i.received_total + seg_size;
          if (!item_i.size_flag) begin
            result_o.status = sdochk_pkg::ST_SUCCESS;
          end else begin
            state_o.expected_toggle = !state_i.expected_toggle;
            result_o.action         = sdochk_pkg::ACT_CONTINUE;
          end
        end
      end else if (state_i.pending_kind == sdochk_pkg::CMD_DOWNLOAD) begin
        result_o.status = (item_i.command_code != sdochk_pkg::CMD_DOWNLOAD) ?
                          sdochk_pkg::ST_WRONG_SVC : sdochk_pkg::ST_SUCCESS;
      end else if (state_i.pending_kind == sdochk_pkg::CMD_DOWNLOAD_SEG) begin
        result_o.status = (item_i.command_code != sdochk_pkg::CMD_DOWNLOAD_SEG) ?
                          sdochk_pkg::ST_WRONG_SVC : sdochk_pkg::ST_RUNNING;
      end else begin
        result_o.status = sdochk_pkg::ST_UNKNOWN_SVC;
      end

      if (result_o.action == sdochk_pkg::ACT_CONTINUE) begin
        state_o.session_count = sdochk_pkg::next_count(state_i.session_count);
      end else begin
        state_o.xfer_open = 1'b0;
      end
    end
  end

endmodule

FILE: hdl/sdo_transfer_response_checker.sv
// ----------------------------------------------------------------------------
// SDO transfer response checker
// Client side bookkeeping of one CoE SDO transfer: start and response
// classification with running byte total and session counter.
// ----------------------------------------------------------------------------
// Usage:
// Transactions enter on the s_axis channel. tuser tells a start of a new
// transfer (0) from a received mailbox response (1); tdata carries the decoded
// header fields and the two payload dwords. Every input transaction gives
// exactly one result transaction on the m_axis channel: action, status, abort
// code, copy offset and byte count, running total and session counter.
// The input register takes the transaction and the result register is then
// loaded from it. Throughput is one transaction per cycle while the receiver
// takes results; the rate is set by the combinational classify logic
// between the input register and the result register, which also updates
// the transfer state, so each transaction sees the state left by the last.
// When the receiver stalls, the result register holds and the input
// register fills; s_axis_tready drops only when both are occupied.
// Reset clears both pipeline registers and the transfer state: no transfer
// is open, the pending kind is "other" and the session counter is zero.
// ----------------------------------------------------------------------------
module sdo_transfer_response_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, from bit 0 up: command_code, obj_index, obj_subindex, frame_class,
  // toggle_bit, transfer_kind, block_field, size_flag, mailbox_len,
  // payload_word0, payload_word1, zero fill.
  input  logic [sdochk_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: req_type.
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata, from bit 0 up: action, status_code, abort_code, copy_offset,
  // copy_bytes, total_bytes, session_counter, zero fill.
  output logic [sdochk_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  sdochk_pkg::item_t   item_d;
  sdochk_pkg::item_t   item_q;
  logic                in_valid_q;
  sdochk_pkg::state_t  state_q;
  sdochk_pkg::state_t  state_d;
  sdochk_pkg::result_t result_d;
  sdochk_pkg::result_t result_q;
  logic [31:0]         total_q;
  logic [2:0]          count_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign item_d = '{req_type:      s_axis_tuser[0],
                    command_code:  s_axis_tdata[2:0],
                    obj_index:     s_axis_tdata[18:3],
                    obj_subindex:  s_axis_tdata[26:19],
                    frame_class:   s_axis_tdata[28:27],
                    toggle_bit:    s_axis_tdata[29],
                    transfer_kind: s_axis_tdata[30],
                    block_field:   s_axis_tdata[32:31],
                    size_flag:     s_axis_tdata[33],
                    mailbox_len:   s_axis_tdata[49:34],
                    payload_word0: s_axis_tdata[81:50],
                    payload_word1: s_axis_tdata[113:82]};

  sdochk_classify u_classify (
    .item_i   (item_q),
    .state_i  (state_q),
    .result_o (result_d),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{pending_kind:     sdochk_pkg::KIND_OTHER,
                       pending_index:    16'd0,
                       pending_subindex: 8'd0,
                       expected_toggle:  1'b0,
                       buffer_capacity:  32'd0,
                       received_total:   32'd0,
                       session_count:    3'd0,
                       xfer_open:        1'b0};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance) begin
      result_q <= result_d;
      total_q  <= state_d.received_total;
      count_q  <= state_d.session_count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, count_q, total_q, result_q.copy_bytes, result_q.copy_offset,
                          result_q.abort_code, result_q.status, result_q.action};

  // A start always leaves a nonzero session counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.action == sdochk_pkg::ACT_START)) |-> (count_q != 3'd0))
    else $error("session counter zero after start");

  // Abort code is only reported with an aborted status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.status != sdochk_pkg::ST_ABORTED)) |->
      (result_q.abort_code == 32'd0))
    else $error("abort code without aborted status");

  // Unrelated responses copy nothing and report running status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.action == sdochk_pkg::ACT_NONE)) |->
      ((result_q.status == sdochk_pkg::ST_RUNNING) && (result_q.copy_bytes == 32'd0)))
    else $error("unrelated response with data or status");

  // The copy offset is one of the three payload positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((result_q.copy_offset == sdochk_pkg::OFFS_HEADER) ||
                     (result_q.copy_offset == sdochk_pkg::OFFS_WORD1) ||
                     (result_q.copy_offset == sdochk_pkg::OFFS_WORD2)))
    else $error("copy offset out of range");

  // Input backpressure only when both registers are occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

endmodule

FILE: bench/sdo_transfer_response_checker_tb.sv
// ----------------------------------------------------------------------------
// SDO transfer response checker testbench
// Drives start and response transactions into the checker with bursty
// traffic and a stalling receiver. Every transaction is classified by an
// in-bench model of the client transfer state, and the expected outcome is
// compared field by field with the next result transaction.
// ----------------------------------------------------------------------------
module sdo_transfer_response_checker_tb;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 80;

  typedef struct {
    sdochk_pkg::item_t hdr;
    bit                idle_first;
  } sdo_txn_t;

  typedef struct {
    sdochk_pkg::action_e action;
    sdochk_pkg::status_e status;
    logic [31:0]         abort_code;
    logic [3:0]          copy_offset;
    logic [31:0]         copy_bytes;
    logic [31:0]         total_bytes;
    logic [2:0]          session_counter;
  } sdo_outcome_t;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [sdochk_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]                         s_axis_tuser  = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [sdochk_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  sdo_transfer_response_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Client transfer state as the bench sees it.
  logic [2:0]  xfer_kind   = sdochk_pkg::KIND_OTHER;
  logic [15:0] xfer_index  = '0;
  logic [7:0]  xfer_sub    = '0;
  logic        want_toggle = 1'b0;
  logic [31:0] cap_bytes   = '0;
  logic [31:0] got_bytes   = '0;
  logic [2:0]  sess_cnt    = '0;
  logic        xfer_active = 1'b0;

  sdo_txn_t     pending_q[$];
  sdo_outcome_t expected_q[$];

  int unsigned total_txns   = 0;
  int unsigned useful_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned starts_cnt   = 0;
  int unsigned err_cnt      = 0;
  int unsigned rx_seen      = 0;
  int unsigned cont_tally   = 0;
  int unsigned status_tally[0:6];

  // --------------------------------------------------------------------------
  // Outcome of one transaction, updating the transfer state.
  // --------------------------------------------------------------------------
  task automatic classify(input sdochk_pkg::item_t it, output sdo_outcome_t r);
    logic [31:0] seg_len;
    logic [31:0] body_len;
    logic [3:0]  seg_offs;
    logic [32:0] sum;
    logic        addr_ok;
    r.action      = sdochk_pkg::ACT_NONE;
    r.status      = sdochk_pkg::ST_RUNNING;
    r.abort_code  = '0;
    r.copy_offset = '0;
    r.copy_bytes  = '0;
    if (it.req_type == sdochk_pkg::REQ_START) begin
      xfer_kind   = it.command_code;
      xfer_index  = it.obj_index;
      xfer_sub    = it.obj_subindex;
      cap_bytes   = it.payload_word0;
      got_bytes   = '0;
      want_toggle = 1'b0;
      xfer_active = 1'b1;
      sess_cnt    = (sess_cnt == sdochk_pkg::COUNTER_MAX) ? sdochk_pkg::COUNTER_FIRST :
                                                             sess_cnt + 3'd1;
      r.action    = sdochk_pkg::ACT_START;
    end else begin
      // The address only matters for plain upload and download requests.
      addr_ok = !((xfer_kind == sdochk_pkg::CMD_UPLOAD ||
                   xfer_kind == sdochk_pkg::CMD_DOWNLOAD) &&
                  (it.obj_index != xfer_index || it.obj_subindex != xfer_sub));
      if (xfer_active && it.frame_class == sdochk_pkg::FCLS_SDO && addr_ok) begin
        r.action = sdochk_pkg::ACT_FINALIZE;
        if (it.command_code == sdochk_pkg::CMD_ABORT) begin
          r.status     = sdochk_pkg::ST_ABORTED;
          r.abort_code = it.payload_word0;
        end else begin
          case (xfer_kind)
            sdochk_pkg::CMD_UPLOAD: begin
              if (it.command_code != sdochk_pkg::CMD_UPLOAD) begin
                r.status = sdochk_pkg::ST_WRONG_SVC;
              end else if (it.transfer_kind) begin
                seg_len = 32'(sdochk_pkg::EXP_MAX_BYTES) - 32'(it.block_field);
                if (cap_bytes < seg_len) begin
                  r.status = sdochk_pkg::ST_BUF_SMALL;
                end else begin
                  r.copy_offset = sdochk_pkg::OFFS_HEADER;
                  r.copy_bytes  = seg_len;
                  got_bytes     = seg_len;
                  r.status      = sdochk_pkg::ST_SUCCESS;
                end
              end else begin
                body_len = (it.mailbox_len >= sdochk_pkg::MBX_HDR_LEN) ?
                           32'(it.mailbox_len - sdochk_pkg::MBX_HDR_LEN) : '0;
                if (cap_bytes < it.payload_word0) begin
                  r.status = sdochk_pkg::ST_BUF_SMALL;
                end else if (body_len >= it.payload_word0) begin
                  r.copy_offset = sdochk_pkg::OFFS_WORD1;
                  r.copy_bytes  = it.payload_word0;
                  got_bytes     = it.payload_word0;
                  r.status      = sdochk_pkg::ST_SUCCESS;
                end else if (it.payload_word1 > cap_bytes) begin
                  r.status = sdochk_pkg::ST_BUF_SMALL;
                end else begin
                  // Data does not fit one frame: switch to segmented upload.
                  r.copy_offset = sdochk_pkg::OFFS_WORD2;
                  r.copy_bytes  = it.payload_word1;
                  got_bytes     = it.payload_word1;
                  xfer_kind     = sdochk_pkg::CMD_UPLOAD_SEG;
                  want_toggle   = 1'b0;
                  r.action      = sdochk_pkg::ACT_CONTINUE;
                end
              end
            end
            sdochk_pkg::CMD_UPLOAD_SEG: begin
              if (it.command_code != sdochk_pkg::CMD_UPLOAD_SEG) begin
                r.status = sdochk_pkg::ST_WRONG_SVC;
              end else if (it.toggle_bit != want_toggle) begin
                r.status = sdochk_pkg::ST_BAD_TOGGLE;
              end else begin
                // A header-only frame carries up to seven bytes in place.
                if (it.mailbox_len == sdochk_pkg::MBX_HDR_LEN) begin
                  seg_len  = 32'(sdochk_pkg::SEG_MAX_BYTES - {it.size_flag, it.block_field});
                  seg_offs = sdochk_pkg::OFFS_HEADER;
                end else begin
                  seg_len  = it.payload_word0;
                  seg_offs = sdochk_pkg::OFFS_WORD1;
                end
                sum = {1'b0, got_bytes} + {1'b0, seg_len};
                if (sum > {1'b0, cap_bytes}) begin
                  r.status = sdochk_pkg::ST_BUF_SMALL;
                end else begin
                  r.copy_offset = seg_offs;
                  r.copy_bytes  = seg_len;
                  got_bytes     = sum[31:0];
                  if (!it.size_flag) begin
                    r.status = sdochk_pkg::ST_SUCCESS;
                  end else begin
                    want_toggle = ~want_toggle;
                    r.action    = sdochk_pkg::ACT_CONTINUE;
                  end
                end
              end
            end
            sdochk_pkg::CMD_DOWNLOAD: begin
              r.status = (it.command_code == sdochk_pkg::CMD_DOWNLOAD) ?
                         sdochk_pkg::ST_SUCCESS : sdochk_pkg::ST_WRONG_SVC;
            end
            sdochk_pkg::CMD_DOWNLOAD_SEG: begin
              r.status = (it.command_code == sdochk_pkg::CMD_DOWNLOAD_SEG) ?
                         sdochk_pkg::ST_RUNNING : sdochk_pkg::ST_WRONG_SVC;
            end
            default: begin
              r.status = sdochk_pkg::ST_UNKNOWN_SVC;
            end
          endcase
        end
        if (r.action == sdochk_pkg::ACT_CONTINUE) begin
          sess_cnt = (sess_cnt == sdochk_pkg::COUNTER_MAX) ? sdochk_pkg::COUNTER_FIRST :
                                                              sess_cnt + 3'd1;
        end else begin
          xfer_active = 1'b0;
        end
      end
    end
    r.total_bytes     = got_bytes;
    r.session_counter = sess_cnt;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic sdochk_pkg::item_t make_hdr(logic req, logic [2:0] cmd,
                                                 logic [15:0] idx, logic [7:0] sub);
    sdochk_pkg::item_t h;
    h.req_type      = req;
    h.command_code  = cmd;
    h.obj_index     = idx;
    h.obj_subindex  = sub;
    h.frame_class   = sdochk_pkg::FCLS_SDO;
    h.toggle_bit    = 1'($urandom);
    h.transfer_kind = 1'($urandom);
    h.block_field   = 2'($urandom);
    h.size_flag     = 1'($urandom);
    h.mailbox_len   = 16'($urandom);
    h.payload_word0 = $urandom;
    h.payload_word1 = $urandom;
    return h;
  endfunction

  task automatic push_txn(sdochk_pkg::item_t h, bit idle_first);
    sdo_txn_t t;
    t.hdr        = h;
    t.idle_first = idle_first;
    pending_q.insert(pending_q.size(), t);
    total_txns++;
    if (h.req_type == sdochk_pkg::REQ_START || h.frame_class == sdochk_pkg::FCLS_SDO) begin
      useful_cnt++;
    end
  endtask

  task automatic open_xfer(logic [2:0] kind, logic [15:0] idx, logic [7:0] sub,
                           logic [31:0] cap, bit idle_first);
    sdochk_pkg::item_t h;
    h = make_hdr(sdochk_pkg::REQ_START, kind, idx, sub);
    h.payload_word0 = cap;
    push_txn(h, idle_first);
  endtask

  task automatic gen_directed();
    sdochk_pkg::item_t h;
    // Response while no transfer is open.
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h0000, 8'h00);
    push_txn(h, 1'b0);
    // Other pending kinds: unknown service, with abort taking precedence.
    open_xfer(sdochk_pkg::KIND_OTHER, 16'h0000, 8'h00, 32'h0000_0000, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_ABORT + 3'd1, 16'h0001, 8'h01);
    push_txn(h, 1'b0);
    open_xfer(sdochk_pkg::KIND_OTHER + 3'd3, 16'h0000, 8'h00, 32'h0000_0000, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_ABORT, 16'hFFFF, 8'hFF);
    h.payload_word0 = 32'hFFFF_FFFF;
    push_txn(h, 1'b0);
    // Expedited upload, full size, then one that does not fit.
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'hFFFF, 8'hFF);
    h.transfer_kind = 1'b1;
    h.block_field   = 2'd0;
    push_txn(h, 1'b0);
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'h1000, 8'h01, 32'd2, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h1000, 8'h01);
    h.transfer_kind = 1'b1;
    h.block_field   = 2'd0;
    push_txn(h, 1'b0);
    // Wrong address and non-SDO frames are ignored; then a one-frame upload.
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'h2000, 8'h02, 32'd100, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h2001, 8'h02);
    push_txn(h, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h2000, 8'h02);
    h.frame_class = 2'd3;
    push_txn(h, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h2000, 8'h02);
    h.transfer_kind = 1'b0;
    h.mailbox_len   = 16'd20;
    h.payload_word0 = 32'd10;
    push_txn(h, 1'b0);
    // Short frame goes segmented, one segment, then a repeated toggle.
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'h2000, 8'h02, 32'd100, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h2000, 8'h02);
    h.transfer_kind = 1'b0;
    h.mailbox_len   = 16'd5;
    h.payload_word0 = 32'd10;
    h.payload_word1 = 32'd8;
    push_txn(h, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD_SEG, 16'h0000, 8'h00);
    h.toggle_bit  = 1'b0;
    h.mailbox_len = sdochk_pkg::MBX_HDR_LEN;
    h.block_field = 2'd1;
    h.size_flag   = 1'b1;
    push_txn(h, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD_SEG, 16'h0000, 8'h00);
    h.toggle_bit = 1'b0;
    push_txn(h, 1'b0);
    // Buffer too small for the announced size, and for the first segment.
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'h3000, 8'h00, 32'd50, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h3000, 8'h00);
    h.transfer_kind = 1'b0;
    h.mailbox_len   = 16'd0;
    h.payload_word0 = 32'd60;
    push_txn(h, 1'b0);
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'h3000, 8'h00, 32'd50, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h3000, 8'h00);
    h.transfer_kind = 1'b0;
    h.mailbox_len   = sdochk_pkg::MBX_HDR_LEN;
    h.payload_word0 = 32'd20;
    h.payload_word1 = 32'd60;
    push_txn(h, 1'b0);
    // Segmented upload that ends exactly at the buffer capacity.
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'h4000, 8'h10, 32'd20, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h4000, 8'h10);
    h.transfer_kind = 1'b0;
    h.mailbox_len   = 16'd12;
    h.payload_word0 = 32'd10;
    h.payload_word1 = 32'd15;
    push_txn(h, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD_SEG, 16'h0000, 8'h00);
    h.toggle_bit    = 1'b0;
    h.mailbox_len   = 16'd30;
    h.payload_word0 = 32'd5;
    h.size_flag     = 1'b0;
    push_txn(h, 1'b0);
    // Segment pending from the start: overflow, then a seven byte segment.
    open_xfer(sdochk_pkg::CMD_UPLOAD_SEG, 16'h5000, 8'h00, 32'd0, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD_SEG, 16'h5000, 8'h00);
    h.toggle_bit    = 1'b0;
    h.mailbox_len   = 16'd11;
    h.payload_word0 = 32'd1;
    push_txn(h, 1'b0);
    open_xfer(sdochk_pkg::CMD_UPLOAD_SEG, 16'h0000, 8'h00, 32'd7, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD_SEG, 16'hFFFF, 8'hFF);
    h.toggle_bit  = 1'b0;
    h.mailbox_len = sdochk_pkg::MBX_HDR_LEN;
    h.block_field = 2'd0;
    h.size_flag   = 1'b0;
    push_txn(h, 1'b0);
    // Wrong service on upload, and the download kinds.
    open_xfer(sdochk_pkg::CMD_UPLOAD, 16'h6000, 8'h01, 32'd64, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_DOWNLOAD, 16'h6000, 8'h01);
    push_txn(h, 1'b0);
    open_xfer(sdochk_pkg::CMD_DOWNLOAD, 16'h1234, 8'h01, 32'd0, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_DOWNLOAD, 16'h1234, 8'h01);
    push_txn(h, 1'b0);
    open_xfer(sdochk_pkg::CMD_DOWNLOAD, 16'h1234, 8'h01, 32'd0, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, 16'h1234, 8'h01);
    push_txn(h, 1'b0);
    open_xfer(sdochk_pkg::CMD_DOWNLOAD_SEG, 16'h1234, 8'h01, 32'd0, 1'b0);
    h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_DOWNLOAD_SEG, 16'hABCD, 8'h55);
    push_txn(h, 1'b0);
  endtask

  task automatic gen_segmented(logic [15:0] idx, logic [7:0] sub);
    sdochk_pkg::item_t h;
    logic [31:0]       cap;
    logic [31:0]       first_seg;
    logic              tog;
    int unsigned       nseg;
    first_seg = $urandom_range(0, 300);
    cap = first_seg + 1 + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) :
                                                          $urandom_range(100, 3000));
    if ($urandom_range(0, 9) == 0) begin
      cap = 32'hFFFF_FFFF;
    end
    if ($urandom_range(0, 4) == 0) begin
      open_xfer(sdochk_pkg::CMD_UPLOAD_SEG, idx, sub, cap, 1'b0);
    end else begin
      open_xfer(sdochk_pkg::CMD_UPLOAD, idx, sub, cap, 1'b0);
      h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, idx, sub);
      h.transfer_kind = 1'b0;
      h.payload_word0 = cap;
      h.mailbox_len   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 9)) :
                        sdochk_pkg::MBX_HDR_LEN +
                        16'($urandom_range(0, (cap > 100) ? 99 : cap - 1));
      h.payload_word1 = first_seg;
      if ($urandom_range(0, 9) == 0 && cap != 32'hFFFF_FFFF) begin
        h.payload_word1 = cap + 1 + $urandom_range(0, 50);
      end
      push_txn(h, 1'b0);
    end
    tog  = 1'b0;
    nseg = $urandom_range(1, 8);
    for (int unsigned i = 0; i < nseg; i++) begin
      h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD_SEG,
                   16'($urandom), 8'($urandom));
      h.toggle_bit = ($urandom_range(0, 12) == 0) ? ~tog : tog;
      h.size_flag  = (i + 1 < nseg);
      case ($urandom_range(0, 39))
        0:       h.command_code = sdochk_pkg::CMD_DOWNLOAD;
        1:       h.command_code = sdochk_pkg::CMD_ABORT;
        default: h.command_code = sdochk_pkg::CMD_UPLOAD_SEG;
      endcase
      case ($urandom_range(0, 3))
        0, 1:    h.mailbox_len = sdochk_pkg::MBX_HDR_LEN;
        2:       h.mailbox_len = 16'($urandom_range(0, 9));
        default: h.mailbox_len = 16'($urandom_range(11, 600));
      endcase
      h.payload_word0 = ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(0, 120);
      push_txn(h, 1'b0);
      tog = ~tog;
    end
  endtask

  task automatic gen_random();
    sdochk_pkg::item_t h;
    logic [15:0]       idx;
    logic [7:0]        sub;
    logic [31:0]       cap;
    idx = 16'($urandom);
    sub = 8'($urandom);
    case ($urandom_range(0, 11))
      0, 1: begin
        cap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : $urandom;
        open_xfer(sdochk_pkg::CMD_UPLOAD, idx, sub, cap, 1'b0);
        h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, idx, sub);
        h.transfer_kind = 1'b1;
        push_txn(h, 1'b0);
      end
      2, 3: begin
        cap = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
        open_xfer(sdochk_pkg::CMD_UPLOAD, idx, sub, cap, 1'b0);
        h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_UPLOAD, idx, sub);
        h.transfer_kind = 1'b0;
        h.payload_word0 = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1500);
        h.mailbox_len   = ($urandom_range(0, 1) == 0) ?
                          16'(h.payload_word0 + sdochk_pkg::MBX_HDR_LEN +
                              $urandom_range(0, 40)) :
                          16'($urandom_range(0, 60));
        push_txn(h, 1'b0);
      end
      4, 5, 6: begin
        gen_segmented(idx, sub);
      end
      7: begin
        open_xfer(sdochk_pkg::CMD_DOWNLOAD, idx, sub, $urandom, 1'b0);
        if ($urandom_range(0, 5) == 0) begin
          h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_DOWNLOAD,
                       idx ^ 16'(1 << $urandom_range(0, 15)), sub);
          push_txn(h, 1'b0);
        end
        h = make_hdr(sdochk_pkg::REQ_RESPONSE,
                     ($urandom_range(0, 4) == 0) ? sdochk_pkg::CMD_UPLOAD :
                                                   sdochk_pkg::CMD_DOWNLOAD,
                     idx, sub);
        push_txn(h, 1'b0);
      end
      8: begin
        open_xfer(sdochk_pkg::CMD_DOWNLOAD_SEG, idx, sub, $urandom, 1'b0);
        h = make_hdr(sdochk_pkg::REQ_RESPONSE,
                     ($urandom_range(0, 4) == 0) ? sdochk_pkg::CMD_UPLOAD_SEG :
                                                   sdochk_pkg::CMD_DOWNLOAD_SEG,
                     16'($urandom), 8'($urandom));
        push_txn(h, 1'b0);
      end
      9: begin
        open_xfer(sdochk_pkg::KIND_OTHER + 3'($urandom_range(0, 3)), idx, sub, $urandom,
                  1'b0);
        h = make_hdr(sdochk_pkg::REQ_RESPONSE, 3'($urandom), 16'($urandom), 8'($urandom));
        push_txn(h, 1'b0);
      end
      10: begin
        open_xfer(3'($urandom_range(0, 3)), idx, sub, $urandom, 1'b0);
        h = make_hdr(sdochk_pkg::REQ_RESPONSE, sdochk_pkg::CMD_ABORT, idx, sub);
        push_txn(h, 1'b0);
      end
      default: begin
        // Stray traffic: any class, any command, any address.
        h = make_hdr(sdochk_pkg::REQ_RESPONSE, 3'($urandom), 16'($urandom), 8'($urandom));
        h.frame_class = 2'($urandom);
        push_txn(h, 1'b0);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side: bursts of transactions separated by random gaps.
  // --------------------------------------------------------------------------
  int                burst_left = 0;
  int                gap_left   = 0;
  sdochk_pkg::item_t on_bus;
  sdo_txn_t          next_txn;
  sdo_outcome_t      predicted;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        classify(on_bus, predicted);
        expected_q.insert(expected_q.size(), predicted);
        accepted_cnt++;
        if (on_bus.req_type == sdochk_pkg::REQ_START) begin
          starts_cnt++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].idle_first && expected_q.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          next_txn = pending_q.pop_front();
          on_bus   = next_txn.hdr;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= on_bus.req_type;
          s_axis_tdata  <= {6'd0, on_bus.payload_word1, on_bus.payload_word0,
                            on_bus.mailbox_len, on_bus.size_flag, on_bus.block_field,
                            on_bus.transfer_kind, on_bus.toggle_bit, on_bus.frame_class,
                            on_bus.obj_subindex, on_bus.obj_index, on_bus.command_code};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: result checking and receiver stalls.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch(name, got, want);
    end
  endtask

  int unsigned  rx_cycle  = 0;
  int unsigned  rx_mode   = 0;
  int unsigned  hold_left = 0;
  sdo_outcome_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_q.pop_front();
          check_field("action", 32'(m_axis_tdata[1:0]), 32'(want.action));
          check_field("status_code", 32'(m_axis_tdata[4:2]), 32'(want.status));
          check_field("abort_code", m_axis_tdata[36:5], want.abort_code);
          check_field("copy_offset", 32'(m_axis_tdata[40:37]), 32'(want.copy_offset));
          check_field("copy_bytes", m_axis_tdata[72:41], want.copy_bytes);
          check_field("total_bytes", m_axis_tdata[104:73], want.total_bytes);
          check_field("session_counter", 32'(m_axis_tdata[107:105]),
                      32'(want.session_counter));
          status_tally[want.status]++;
          if (want.action == sdochk_pkg::ACT_CONTINUE) begin
            cont_tally++;
          end
          rx_seen++;
          // Now and then stop taking results long enough to back up the input.
          if (rx_seen % 400 == 150) begin
            hold_left = LONG_HOLD;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_cycle % 256 == 0) begin
          rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (rx_cycle % 5 < 2);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either side.
  // --------------------------------------------------------------------------
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: %0d of %0d transactions accepted, %0d results outstanding",
                 accepted_cnt, total_txns, expected_q.size());
        $display("sdo_transfer_response_checker_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    foreach (status_tally[i]) begin
      status_tally[i] = 0;
    end
    gen_directed();
    while (useful_cnt < RANDOM_ITEMS) begin
      // Occasionally let the block drain completely before the next transfer.
      if ($urandom_range(0, 199) == 0) begin
        open_xfer(3'($urandom), 16'($urandom), 8'($urandom), $urandom, 1'b1);
      end
      gen_random();
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_cnt != total_txns || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      report_mismatch("results never arrived", 32'(expected_q.size()), '0);
    end
    $display("covered %0d transactions (%0d starts), %0d results, %0d continued segments",
             accepted_cnt, starts_cnt, rx_seen, cont_tally);
    $display("statuses: ok %0d, wrong %0d, small %0d, toggle %0d, unknown %0d, abort %0d",
             status_tally[sdochk_pkg::ST_SUCCESS], status_tally[sdochk_pkg::ST_WRONG_SVC],
             status_tally[sdochk_pkg::ST_BUF_SMALL], status_tally[sdochk_pkg::ST_BAD_TOGGLE],
             status_tally[sdochk_pkg::ST_UNKNOWN_SVC], status_tally[sdochk_pkg::ST_ABORTED]);
    if (err_cnt == 0) begin
      $display("sdo_transfer_response_checker_tb: done, clean");
    end else begin
      $display("sdo_transfer_response_checker_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sdochk_pkg.sv
hdl/sdochk_classify.sv
hdl/sdo_transfer_response_checker.sv
bench/sdo_transfer_response_checker_tb.sv
